/* sv/wdd_pkg.sv */
// Shared types and constants for the weight drop event detector.
// No dependencies; imported by the channel interfaces and the top level.
package wdd_pkg;

  localparam int unsigned REG_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned AMOUNT_W   = 13;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned TENTHS_W   = 14;

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_RESET_TOTAL = 2'd1,
    OP_FORCE_BASE  = 2'd2,
    OP_CLEAR_ALL   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_BASELINE_SET = 3'd0,
    EV_DRIFT        = 3'd1,
    EV_HELD         = 3'd2,
    EV_SMALL_DRINK  = 3'd3,
    EV_LARGE_DRINK  = 3'd4,
    EV_REFILL       = 3'd5,
    EV_CMD_DONE     = 3'd6
  } event_e;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DRINK_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_DRINK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_STEP = 3'd4;

  localparam logic [REG_W-1:0] DRINK_MIN_RST    = 10'd30;
  localparam logic [REG_W-1:0] LARGE_DRINK_RST  = 10'd150;
  localparam logic [REG_W-1:0] REFILL_MIN_RST   = 10'd100;
  localparam logic [REG_W-1:0] DRIFT_MAX_RST    = 10'd10;
  localparam logic [REG_W-1:0] DISPLAY_STEP_RST = 10'd50;

  // Valid baseline window in tenths of ml
  localparam logic signed [LEVEL_W-1:0] BASE_MIN_TENTH = -16'sd1000;
  localparam logic signed [LEVEL_W-1:0] BASE_MAX_TENTH = 16'sd10000;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // x / 10 as (x * 52429) >> 19, exact for x below 43699
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // Whole ml to tenths: 10*x = 8*x + 2*x
  function automatic logic [TENTHS_W-1:0] to_tenths(input logic [REG_W-1:0] x);
    logic [TENTHS_W-1:0] w;
    w = {{(TENTHS_W-REG_W){1'b0}}, x};
    return (w << 3) + (w << 1);
  endfunction

endpackage

/* sv/wdd_in_if.sv */
// Sample / command channel of the detector: valid, ready and payload.
// Depends on wdd_pkg.
interface wdd_in_if import wdd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [LEVEL_W-1:0] level_tenth_ml;

  modport source (output valid, opcode, level_tenth_ml, input ready);
  modport sink   (input valid, opcode, level_tenth_ml, output ready);
endinterface

/* sv/wdd_out_if.sv */
// Result channel of the detector: valid, ready and payload.
// Depends on wdd_pkg.
interface wdd_out_if import wdd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          event_res;
  logic [AMOUNT_W-1:0] drunk_ml;
  logic [TOTAL_W-1:0]  day_sum_ml;
  logic [TOTAL_W-1:0]  drinks_today;
  logic                display_refresh;

  modport source (output valid, event_res, drunk_ml, day_sum_ml, drinks_today,
                  display_refresh, input ready);
  modport sink   (input valid, event_res, drunk_ml, day_sum_ml, drinks_today,
                  display_refresh, output ready);
endinterface

/* sv/weight_drop_event_detector_unit.sv */
// The input register holds an accepted item until the result register is free, which
// then takes it. Throughput: one item per cycle while out_o.ready does not stall;
// the baseline/total update is a combinational loop through the delta subtract,
// divide-by-ten multiply and saturating add, closed by the state registers.
// Reset: rst_ni clears both pipeline valids, baseline, daily total, count and
// last shown total, and loads the threshold registers with their defaults.
module weight_drop_event_detector_unit import wdd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  wdd_in_if.sink               in_i,
  wdd_out_if.source            out_o
);

  // Threshold registers
  logic [REG_W-1:0] drink_min_q, large_drink_q, refill_min_q, drift_max_q, display_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drink_min_q    <= DRINK_MIN_RST;
      large_drink_q  <= LARGE_DRINK_RST;
      refill_min_q   <= REFILL_MIN_RST;
      drift_max_q    <= DRIFT_MAX_RST;
      display_step_q <= DISPLAY_STEP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DRINK_MIN)    drink_min_q    <= cfg_data_i;
      if (cfg_idx_i == REG_LARGE_DRINK)  large_drink_q  <= cfg_data_i;
      if (cfg_idx_i == REG_REFILL_MIN)   refill_min_q   <= cfg_data_i;
      if (cfg_idx_i == REG_DRIFT_MAX)    drift_max_q    <= cfg_data_i;
      if (cfg_idx_i == REG_DISPLAY_STEP) display_step_q <= cfg_data_i;
    end
  end

  // Handshake
  logic s1_valid_q, out_valid_q;
  logic s1_fire, in_fire, out_free;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  // Input register
  op_e                       s1_op_q;
  logic signed [LEVEL_W-1:0] s1_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_e'(in_i.opcode);
      s1_level_q <= in_i.level_tenth_ml;
    end
  end

  // Detector state
  logic signed [LEVEL_W-1:0] base_q, base_d;
  logic                      base_vld_q, base_vld_d;
  logic [TOTAL_W-1:0]        total_q, total_d, count_q, count_d, shown_q, shown_d;

  // Datapath
  logic signed [16:0]   delta, delta_neg_refill, drink_t, large_t, drift_t;
  logic [16:0]          mag;
  logic [32:0]          div_prod;
  logic [AMOUNT_W-1:0]  amount;
  logic [16:0]          sum;
  logic [TOTAL_W-1:0]   total_sat, shown_diff;
  event_e               ev_d;
  logic [AMOUNT_W-1:0]  amount_d;
  logic                 refresh_d;

  assign delta   = {base_q[15], base_q} - {s1_level_q[15], s1_level_q};
  assign drink_t = $signed({3'b000, to_tenths(drink_min_q)});
  assign large_t = $signed({3'b000, to_tenths(large_drink_q)});
  assign drift_t = $signed({3'b000, to_tenths(drift_max_q)});
  assign delta_neg_refill = -$signed({3'b000, to_tenths(refill_min_q)});
  assign mag     = delta[16] ? 17'(-delta) : 17'(delta);

  // delta is non-negative and below 43699 whenever the quotient is used
  assign div_prod  = {17'd0, delta[15:0]} * {16'd0, DIV10_MUL};
  assign amount    = div_prod[DIV10_SHIFT +: AMOUNT_W];
  assign sum       = {1'b0, total_q} + {4'd0, amount};
  assign total_sat = sum[16] ? TOTAL_MAX : sum[15:0];
  assign shown_diff = (total_sat >= shown_q) ? total_sat - shown_q : shown_q - total_sat;

  always_comb begin
    base_d     = base_q;
    base_vld_d = base_vld_q;
    total_d    = total_q;
    count_d    = count_q;
    shown_d    = shown_q;
    ev_d       = EV_CMD_DONE;
    amount_d   = '0;
    refresh_d  = 1'b0;
    unique case (s1_op_q)
      OP_RESET_TOTAL: begin
        total_d = '0;
        count_d = '0;
        shown_d = '0;
      end
      OP_FORCE_BASE: begin
        base_d     = s1_level_q;
        base_vld_d = 1'b1;
      end
      OP_CLEAR_ALL: begin
        base_d     = '0;
        base_vld_d = 1'b0;
        total_d    = '0;
        count_d    = '0;
        shown_d    = '0;
      end
      OP_SAMPLE: begin
        priority if (!base_vld_q || base_q < BASE_MIN_TENTH || base_q > BASE_MAX_TENTH) begin
          base_d     = s1_level_q;
          base_vld_d = 1'b1;
          ev_d       = EV_BASELINE_SET;
        end else if (delta >= drink_t) begin
          ev_d     = (delta >= large_t) ? EV_LARGE_DRINK : EV_SMALL_DRINK;
          amount_d = amount;
          base_d   = s1_level_q;
          total_d  = total_sat;
          count_d  = (count_q == TOTAL_MAX) ? count_q : count_q + 16'd1;
          if (shown_diff >= {6'd0, display_step_q}) begin
            refresh_d = 1'b1;
            shown_d   = total_sat;
          end
        end else if (delta <= delta_neg_refill) begin
          base_d = s1_level_q;
          ev_d   = EV_REFILL;
        end else if (mag < 17'(drift_t)) begin
          base_d = s1_level_q;
          ev_d   = EV_DRIFT;
        end else begin
          ev_d = EV_HELD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      base_vld_q <= 1'b0;
      total_q    <= '0;
      count_q    <= '0;
      shown_q    <= '0;
    end else if (s1_fire) begin
      base_q     <= base_d;
      base_vld_q <= base_vld_d;
      total_q    <= total_d;
      count_q    <= count_d;
      shown_q    <= shown_d;
    end
  end

  // Result register
  event_e              out_ev_q;
  logic [AMOUNT_W-1:0] out_amount_q;
  logic [TOTAL_W-1:0]  out_total_q, out_count_q;
  logic                out_refresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ev_q      <= ev_d;
      out_amount_q  <= amount_d;
      out_total_q   <= total_d;
      out_count_q   <= count_d;
      out_refresh_q <= refresh_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_res       = out_ev_q;
  assign out_o.drunk_ml        = out_amount_q;
  assign out_o.day_sum_ml      = out_total_q;
  assign out_o.drinks_today    = out_count_q;
  assign out_o.display_refresh = out_refresh_q;

  // Checks
  a_amount_only_drink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ev_q != EV_SMALL_DRINK && out_ev_q != EV_LARGE_DRINK)
      |-> (out_amount_q == '0 && !out_refresh_q))
    else $error("amount or refresh set on a non-drink result");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_op_q == OP_SAMPLE) |=> (count_q >= $past(count_q)))
    else $error("drink count decreased on a sample");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("advanced item produced no result");

endmodule
